/* rtl/gcr_telemetry_frame_decoder_macros.svh */
// ----------------------------------------------------------------------------
// gcr telemetry frame decoder assertion macros
// shared concurrent check forms, sampled on clock and held off in reset
// ----------------------------------------------------------------------------
`ifndef GCR_TELEMETRY_FRAME_DECODER_MACROS_SVH
`define GCR_TELEMETRY_FRAME_DECODER_MACROS_SVH

// same-cycle implication
`define GTFD_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define GTFD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

/* rtl/gtfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtfd_pkg
// widths, constants, gcr table and the pipeline beat type of the decoder
// ----------------------------------------------------------------------------
package gtfd_pkg;

   localparam int LineW    = 21;
   localparam int DataW    = 20;
   localparam int CodeW    = 5;
   localparam int NibW     = 4;
   localparam int NumCodes = 4;
   localparam int PayW     = 12;
   localparam int KindW    = 3;
   localparam int ReadW    = 8;
   localparam int PeriodW  = 16;
   localparam int ErpmW    = 26;
   localparam int MantW    = 9;
   localparam int ExpW     = 3;
   localparam int TypedBit = 8;
   localparam int ExpLsb   = 9;

   // divider: quotient bits retired per stage and stage count
   localparam int DivBits   = 4;
   localparam int DivStages = (ErpmW + DivBits - 1) / DivBits;
   localparam int DivW      = DivStages * DivBits;
   localparam int RemW      = MantW;

   localparam logic [DivW-1:0]  MicrosPerMin = DivW'(60000000);
   localparam logic [PayW-1:0]  StoppedCode  = 12'hFFF;
   localparam logic [NibW-1:0]  ChecksumGood = 4'hF;
   localparam logic [KindW-1:0] KindErpm     = 3'd0;

   typedef struct packed {
      logic               ok;
      logic [KindW-1:0]   kind;
      logic [PayW-1:0]    payload;
      logic [PeriodW-1:0] period;
      logic [MantW-1:0]   mant;
      logic [ExpW-1:0]    expo;
      logic               erpm_zero;
      logic [DivW-1:0]    dividend;
      logic [RemW-1:0]    rem;
      logic [DivW-1:0]    quot;
   } gtfd_item_type;

   // returns {hit, nibble}
   function automatic logic [NibW:0] gcr_decode(input logic [CodeW-1:0] code);
      logic [NibW:0] res;
      case (code)
         5'h19:   res = {1'b1, 4'h0};
         5'h1B:   res = {1'b1, 4'h1};
         5'h12:   res = {1'b1, 4'h2};
         5'h13:   res = {1'b1, 4'h3};
         5'h1D:   res = {1'b1, 4'h4};
         5'h15:   res = {1'b1, 4'h5};
         5'h16:   res = {1'b1, 4'h6};
         5'h17:   res = {1'b1, 4'h7};
         5'h1A:   res = {1'b1, 4'h8};
         5'h09:   res = {1'b1, 4'h9};
         5'h0A:   res = {1'b1, 4'hA};
         5'h0B:   res = {1'b1, 4'hB};
         5'h1E:   res = {1'b1, 4'hC};
         5'h0D:   res = {1'b1, 4'hD};
         5'h0E:   res = {1'b1, 4'hE};
         5'h0F:   res = {1'b1, 4'hF};
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

/* rtl/gtfd_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtfd_decode
// two stages: gcr decode with checksum, then frame classification
// ----------------------------------------------------------------------------
module gtfd_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          edt_enable,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [gtfd_pkg::LineW-1:0]    in_line_word,
   output logic                          out_valid,
   input  logic                          out_ready,
   output gtfd_pkg::gtfd_item_type       out_item
);

   typedef struct packed {
      logic                        ok;
      logic [gtfd_pkg::PayW-1:0]   payload;
   } gtfd_frame_type;

   logic                                           s1_valid_ff;
   gtfd_frame_type                                 s1_ff, s1_in;
   logic                                           s2_valid_ff;
   gtfd_pkg::gtfd_item_type                        s2_ff, s2_in;
   logic                                           s1_load, s2_load;

   logic [gtfd_pkg::LineW-1:0]                     diff;
   logic [gtfd_pkg::DataW-1:0]                     data;
   logic [gtfd_pkg::NumCodes-1:0][gtfd_pkg::NibW-1:0] nibs;
   logic [gtfd_pkg::NibW:0]                        look;
   logic [gtfd_pkg::NibW-1:0]                      sum;
   logic                                           hit;
   logic                                           typed;
   logic [gtfd_pkg::MantW-1:0]                     mant;
   logic [gtfd_pkg::ExpW-1:0]                      expo;

   assign s2_load  = !s2_valid_ff || out_ready;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign in_ready = s1_load;

   // stage 1: undo differential coding, map codes, check sum
   always_comb begin
      diff = in_line_word ^ (in_line_word >> 1);
      data = diff[gtfd_pkg::DataW-1:0];
      hit  = 1'b1;
      sum  = '0;
      nibs = '0;
      look = '0;
      for (int n = 0; n < gtfd_pkg::NumCodes; n++) begin
         look    = gtfd_pkg::gcr_decode(data[n*gtfd_pkg::CodeW +: gtfd_pkg::CodeW]);
         hit     = hit & look[gtfd_pkg::NibW];
         nibs[n] = look[gtfd_pkg::NibW-1:0];
         sum     = sum ^ look[gtfd_pkg::NibW-1:0];
      end
      s1_in.ok      = hit && (sum == gtfd_pkg::ChecksumGood);
      s1_in.payload = s1_in.ok ? nibs[gtfd_pkg::NumCodes-1:1] : '0;
   end

   // stage 2: erpm or typed reading, set up the divider
   always_comb begin
      mant  = s1_ff.payload[gtfd_pkg::MantW-1:0];
      expo  = s1_ff.payload[gtfd_pkg::PayW-1:gtfd_pkg::ExpLsb];
      typed = edt_enable && !s1_ff.payload[gtfd_pkg::TypedBit]
              && (s1_ff.payload[gtfd_pkg::PayW-1:gtfd_pkg::TypedBit] != '0);
      s2_in          = '0;
      s2_in.ok       = s1_ff.ok;
      s2_in.payload  = s1_ff.payload;
      s2_in.dividend = gtfd_pkg::MicrosPerMin;
      s2_in.mant     = mant;
      s2_in.expo     = expo;
      if (typed) begin
         s2_in.kind      = s1_ff.payload[gtfd_pkg::PayW-1:gtfd_pkg::ExpLsb];
         s2_in.erpm_zero = 1'b1;
      end else begin
         s2_in.kind      = gtfd_pkg::KindErpm;
         s2_in.period    = {{(gtfd_pkg::PeriodW-gtfd_pkg::MantW){1'b0}}, mant} << expo;
         s2_in.erpm_zero = !s1_ff.ok || (mant == '0)
                           || (s1_ff.payload == gtfd_pkg::StoppedCode);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) s1_valid_ff <= in_valid;
         if (s2_load) s2_valid_ff <= s1_valid_ff;
      end
      if (s1_load && in_valid) s1_ff <= s1_in;
      if (s2_load && s1_valid_ff) s2_ff <= s2_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_item  = s2_ff;

endmodule

/* rtl/gtfd_div_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtfd_div_stage
// one registered slice of the restoring divider, a few quotient bits a stage
// ----------------------------------------------------------------------------
`include "gcr_telemetry_frame_decoder_macros.svh"

module gtfd_div_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  gtfd_pkg::gtfd_item_type in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output gtfd_pkg::gtfd_item_type out_item
);

   logic                         valid_ff;
   gtfd_pkg::gtfd_item_type      item_ff, item_in;
   logic                         load;
   logic [gtfd_pkg::RemW:0]      trial;
   logic [gtfd_pkg::RemW:0]      divisor;
   logic                         qbit;

   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   always_comb begin
      item_in = in_item;
      divisor = {1'b0, in_item.mant};
      trial   = '0;
      qbit    = 1'b0;
      for (int i = 0; i < gtfd_pkg::DivBits; i++) begin
         trial = {item_in.rem, item_in.dividend[gtfd_pkg::DivW-1]};
         item_in.dividend = {item_in.dividend[gtfd_pkg::DivW-2:0], 1'b0};
         qbit = (trial >= divisor);
         if (qbit) trial = trial - divisor;
         item_in.quot = {item_in.quot[gtfd_pkg::DivW-2:0], qbit};
         item_in.rem  = trial[gtfd_pkg::RemW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
      if (load && in_valid) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // partial remainder stays below the divisor
   `GTFD_ASSERT_IMPL(a_rem_below_div, valid_ff && (item_ff.mant != '0), item_ff.rem < item_ff.mant)
   // a held beat keeps its contents
   `GTFD_ASSERT_NEXT(a_stall_holds, valid_ff && !out_ready, valid_ff && $stable(item_ff))

endmodule

/* rtl/gcr_telemetry_frame_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_telemetry_frame_decoder
// decodes one bidirectional gcr telemetry line word into an erpm or typed beat
// ----------------------------------------------------------------------------
// usage
//   req channel: one 21-bit received line word per beat (req_valid/req_ready)
//   rsp channel: ok, kind, payload, reading, elec_period, erpm per beat
//   csr port: csr_wr_en writes csr_wr_data into the edt_enable bit, no wait;
//     write it only while no beat is in flight
// pipeline: ten registers from req to rsp (2 decode stages, 7 divider
//   stages, 1 output register), the first of them loaded on the accepting
//   req edge itself
// throughput: one beat per cycle unless rsp_ready stalls; the divider retires
//   4 quotient bits per stage, so its stage count sets the latency, not the rate
// stall: every stage has its own valid bit and loads when empty or when the
//   stage after it moves, so bubbles close up and req_ready drops only once
//   all ten stages are full behind a stalled rsp_ready
// reset: synchronous; clears all valid bits and edt_enable, so beats in flight
//   are dropped, and no beat is invented across it
// erpm is 60000000 / mantissa, shifted down by the exponent, which equals
//   60000000 / period truncated
// ----------------------------------------------------------------------------
`include "gcr_telemetry_frame_decoder_macros.svh"

module gcr_telemetry_frame_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gtfd_pkg::LineW-1:0]    req_line_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_ok,
   output logic [gtfd_pkg::KindW-1:0]    rsp_kind,
   output logic [gtfd_pkg::PayW-1:0]     rsp_payload,
   output logic [gtfd_pkg::ReadW-1:0]    rsp_reading,
   output logic [gtfd_pkg::PeriodW-1:0]  rsp_elec_period,
   output logic [gtfd_pkg::ErpmW-1:0]    rsp_erpm
);

   // extended telemetry enable register
   logic                                 edt_enable_ff;

   // links between pipeline parts, index 0 is the decoder output
   logic [gtfd_pkg::DivStages:0]         div_valid;
   logic [gtfd_pkg::DivStages:0]         div_ready;
   gtfd_pkg::gtfd_item_type              div_item [gtfd_pkg::DivStages+1];

   // output register
   logic                                 rsp_valid_ff;
   logic                                 rsp_ok_ff;
   logic [gtfd_pkg::KindW-1:0]           rsp_kind_ff;
   logic [gtfd_pkg::PayW-1:0]            rsp_payload_ff;
   logic [gtfd_pkg::PeriodW-1:0]         rsp_period_ff;
   logic [gtfd_pkg::ErpmW-1:0]           rsp_erpm_ff, rsp_erpm_in;
   logic [gtfd_pkg::DivW-1:0]            quot_shifted;
   logic                                 out_load;
   gtfd_pkg::gtfd_item_type              last_item;

   // check helpers
   logic                                 speed_clear;
   logic                                 frame_clear;

   always_ff @(posedge clock) begin
      if (reset) begin
         edt_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         edt_enable_ff <= csr_wr_data;
      end
   end

   // gcr decode and classify
   gtfd_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .edt_enable   (edt_enable_ff),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_line_word (req_line_word),
      .out_valid    (div_valid[0]),
      .out_ready    (div_ready[0]),
      .out_item     (div_item[0])
   );

   // divider chain for 60000000 / mantissa
   for (genvar s = 0; s < gtfd_pkg::DivStages; s++) begin : g_div
      gtfd_div_stage u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[s]),
         .in_ready  (div_ready[s]),
         .in_item   (div_item[s]),
         .out_valid (div_valid[s+1]),
         .out_ready (div_ready[s+1]),
         .out_item  (div_item[s+1])
      );
   end

   assign last_item = div_item[gtfd_pkg::DivStages];
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign div_ready[gtfd_pkg::DivStages] = out_load;

   // apply the exponent to the quotient, zero for stopped, zero-mantissa, typed or bad frames
   always_comb begin
      quot_shifted = last_item.quot >> last_item.expo;
      rsp_erpm_in  = last_item.erpm_zero ? '0 : quot_shifted[gtfd_pkg::ErpmW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= div_valid[gtfd_pkg::DivStages];
      end
      if (out_load && div_valid[gtfd_pkg::DivStages]) begin
         rsp_ok_ff      <= last_item.ok;
         rsp_kind_ff    <= last_item.kind;
         rsp_payload_ff <= last_item.payload;
         rsp_period_ff  <= last_item.period;
         rsp_erpm_ff    <= rsp_erpm_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_payload     = rsp_payload_ff;
   assign rsp_reading     = rsp_payload_ff[gtfd_pkg::ReadW-1:0];
   assign rsp_elec_period = rsp_period_ff;
   assign rsp_erpm        = rsp_erpm_ff;

   assign speed_clear = (rsp_period_ff == '0) && (rsp_erpm_ff == '0);
   assign frame_clear = speed_clear && (rsp_kind_ff == gtfd_pkg::KindErpm)
                        && (rsp_payload_ff == '0);

   // a rejected frame carries nothing
   `GTFD_ASSERT_IMPL(a_bad_frame_clear, rsp_valid_ff && !rsp_ok_ff, frame_clear)
   // typed readings have no period or speed
   `GTFD_ASSERT_IMPL(a_typed_no_speed, rsp_valid_ff && (rsp_kind_ff != 3'd0), speed_clear)
   // a speed needs a good frame with a nonzero period
   `GTFD_ASSERT_IMPL(a_speed_has_period, rsp_valid_ff && (rsp_erpm_ff != '0), rsp_ok_ff && (rsp_period_ff != '0))

endmodule
